[rtl/tsi_pkg.sv]
package tsi_pkg;

  localparam int CornerW = 16;
  localparam int KeyW = 2 * CornerW;

  localparam int QueueDepth = 2;
  localparam int QueuePtrW = 1;

  localparam int EpochW = 8;
  localparam logic [EpochW-1:0] EpochNone = '0;
  localparam logic [EpochW-1:0] EpochFirst = EpochW'(1);
  localparam logic [EpochW-1:0] EpochMax = '1;

  typedef struct packed {
    logic [CornerW-1:0] corner_a;
    logic [CornerW-1:0] corner_b;
    logic [CornerW-1:0] corner_c;
    logic start_pass;
    logic [2:0][KeyW-1:0] edge_keys;
  } tsi_req_t;

endpackage

[rtl/tsi_channels.sv]
interface tsi_in_if;
  logic valid;
  logic ready;
  logic [15:0] corner_a;
  logic [15:0] corner_b;
  logic [15:0] corner_c;
  logic start_pass;

  modport source(output valid, corner_a, corner_b, corner_c, start_pass, input ready);
  modport sink(input valid, corner_a, corner_b, corner_c, start_pass, output ready);
endinterface

interface tsi_out_if;
  logic valid;
  logic ready;
  logic kind;
  logic [15:0] first_index;
  logic [15:0] second_index;
  logic [15:0] third_index;
  logic overflow;
  logic last;

  modport source(output valid, kind, first_index, second_index, third_index, overflow, last,
                 input ready);
  modport sink(input valid, kind, first_index, second_index, third_index, overflow, last,
               output ready);
endinterface

[rtl/tsi_front.sv]
module tsi_front import tsi_pkg::*; #(
  parameter int INDEX_WIDTH = 16
) (
  tsi_in_if.sink in_ch,
  input  logic q_full,
  output logic push,
  output tsi_req_t push_req
);

  localparam logic [CornerW-1:0] CornerMask =
    (INDEX_WIDTH >= CornerW) ? '1 : CornerW'((32'd1 << INDEX_WIDTH) - 32'd1);

  function automatic logic [KeyW-1:0] order_key(logic [CornerW-1:0] p, logic [CornerW-1:0] q);
    return (p < q) ? {p, q} : {q, p};
  endfunction

  logic [CornerW-1:0] a;
  logic [CornerW-1:0] b;
  logic [CornerW-1:0] c;

  assign a = in_ch.corner_a & CornerMask;
  assign b = in_ch.corner_b & CornerMask;
  assign c = in_ch.corner_c & CornerMask;

  assign in_ch.ready = !q_full;
  assign push = in_ch.valid && !q_full;

  always_comb begin
    push_req.corner_a = a;
    push_req.corner_b = b;
    push_req.corner_c = c;
    push_req.start_pass = in_ch.start_pass;
    push_req.edge_keys[0] = order_key(a, b);
    push_req.edge_keys[1] = order_key(b, c);
    push_req.edge_keys[2] = order_key(c, a);
  end

endmodule

[rtl/tsi_queue.sv]
module tsi_queue import tsi_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  tsi_req_t push_req,
  input  logic pop,
  output tsi_req_t head,
  output logic full,
  output logic empty
);

  tsi_req_t q_r [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_r;
  logic [QueuePtrW-1:0] rd_ptr_r;
  logic [QueuePtrW:0] count_r;
  logic [QueuePtrW:0] count_nxt;

  assign head = q_r[rd_ptr_r];
  assign full = (count_r == (QueuePtrW+1)'(QueueDepth));
  assign empty = (count_r == '0);

  always_comb begin
    case ({push, pop})
      2'b10: count_nxt = count_r + (QueuePtrW+1)'(1);
      2'b01: count_nxt = count_r - (QueuePtrW+1)'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_req;
    end
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QueuePtrW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QueuePtrW'(1);
      end
      count_r <= count_nxt;
    end
  end

`ifndef SYNTH
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("request pushed into full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("request popped from empty queue");
`endif

endmodule

[rtl/tsi_back.sv]
module tsi_back import tsi_pkg::*; #(
  parameter int EDGE_MAP_DEPTH = 1024,
  parameter int INDEX_WIDTH = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic [CornerW-1:0] start_index,
  input  tsi_req_t q_head,
  input  logic q_empty,
  output logic pop,
  tsi_out_if.source out_ch
);

  localparam int AW = $clog2(EDGE_MAP_DEPTH);
  localparam int IW = INDEX_WIDTH;
  localparam logic [AW-1:0] LastAddr = AW'(EDGE_MAP_DEPTH - 1);
  localparam logic [AW:0] DepthW = (AW+1)'(EDGE_MAP_DEPTH);

  localparam logic KindVertex = 1'b0;
  localparam logic KindTriangle = 1'b1;

  localparam logic [2:0] EmitVtxAb = 3'd0;
  localparam logic [2:0] EmitVtxBc = 3'd1;
  localparam logic [2:0] EmitVtxCa = 3'd2;
  localparam logic [2:0] EmitTriA = 3'd3;
  localparam logic [2:0] EmitTriB = 3'd4;
  localparam logic [2:0] EmitTriC = 3'd5;
  localparam logic [2:0] EmitTriMid = 3'd6;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ISSUE,
    S_CHECK,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [EpochW-1:0] epoch;
    logic [KeyW-1:0] key;
    logic [IW-1:0] mid;
  } entry_t;

  function automatic logic [AW-1:0] hash_key(logic [KeyW-1:0] k);
    logic [AW-1:0] h;
    logic [AW:0] hx;
    h = '0;
    for (int i = 0; i < KeyW; i++) begin
      h[i % AW] = h[i % AW] ^ k[i];
    end
    hx = {1'b0, h};
    if (hx >= DepthW) begin
      hx = hx - DepthW;
    end
    return hx[AW-1:0];
  endfunction

  function automatic logic [CornerW-1:0] to_field(logic [IW-1:0] v);
    logic [IW+CornerW-1:0] w;
    w = {{CornerW{1'b0}}, v};
    return w[CornerW-1:0];
  endfunction

  entry_t mem [EDGE_MAP_DEPTH];
  entry_t rdata_r;
  logic mem_we;
  logic mem_re;
  logic [AW-1:0] mem_waddr;
  entry_t mem_wdata;

  state_t state_r, state_nxt;
  logic resume_r, resume_nxt;
  logic [EpochW-1:0] cur_epoch_r, cur_epoch_nxt;
  logic [IW:0] next_mid_r, next_mid_nxt;
  logic ovf_r, ovf_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;
  tsi_req_t req_r, req_nxt;
  logic [1:0] sel_r, sel_nxt;
  logic [AW-1:0] probe_addr_r, probe_addr_nxt;
  logic [AW-1:0] probe_cnt_r, probe_cnt_nxt;
  logic [IW-1:0] mid_r [3];
  logic [IW-1:0] mid_nxt [3];
  logic [2:0] vnew_r, vnew_nxt;
  logic [2:0] emit_r, emit_nxt;

  logic out_valid_r, out_valid_nxt;
  logic out_kind_r, out_kind_nxt;
  logic [CornerW-1:0] out_first_r, out_first_nxt;
  logic [CornerW-1:0] out_second_r, out_second_nxt;
  logic [CornerW-1:0] out_third_r, out_third_nxt;
  logic out_ovf_r, out_ovf_nxt;
  logic out_last_r, out_last_nxt;

  logic out_slot_free;
  logic [1:0] sel_step;
  logic [KeyW-1:0] hash_src;
  logic [AW-1:0] hash_idx;
  logic [KeyW-1:0] cur_key;
  logic [KeyW-1:0] emit_key;
  logic [IW+CornerW:0] start_wide;
  logic hit;
  logic slot_empty;
  logic lookup_done;

  assign out_slot_free = !out_valid_r || out_ch.ready;
  assign sel_step = (sel_r == 2'd2) ? 2'd0 : sel_r + 2'd1;
  assign hash_src = (state_r == S_IDLE) ? q_head.edge_keys[0] : req_r.edge_keys[sel_step];
  assign hash_idx = hash_key(hash_src);
  assign cur_key = req_r.edge_keys[sel_r];
  assign emit_key = req_r.edge_keys[emit_r[1:0]];
  assign start_wide = {{(IW+1){1'b0}}, start_index};
  assign hit = (rdata_r.epoch == cur_epoch_r) && (rdata_r.key == cur_key);
  assign slot_empty = (rdata_r.epoch != cur_epoch_r);

  always_comb begin
    state_nxt = state_r;
    resume_nxt = resume_r;
    cur_epoch_nxt = cur_epoch_r;
    next_mid_nxt = next_mid_r;
    ovf_nxt = ovf_r;
    clr_addr_nxt = clr_addr_r;
    req_nxt = req_r;
    sel_nxt = sel_r;
    probe_addr_nxt = probe_addr_r;
    probe_cnt_nxt = probe_cnt_r;
    mid_nxt = mid_r;
    vnew_nxt = vnew_r;
    emit_nxt = emit_r;
    pop = 1'b0;
    mem_we = 1'b0;
    mem_re = 1'b0;
    mem_waddr = probe_addr_r;
    mem_wdata.epoch = cur_epoch_r;
    mem_wdata.key = cur_key;
    mem_wdata.mid = next_mid_r[IW-1:0];
    lookup_done = 1'b0;

    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_kind_nxt = out_kind_r;
    out_first_nxt = out_first_r;
    out_second_nxt = out_second_r;
    out_third_nxt = out_third_r;
    out_ovf_nxt = out_ovf_r;
    out_last_nxt = out_last_r;

    unique case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_waddr = clr_addr_r;
        mem_wdata.epoch = EpochNone;
        if (clr_addr_r == LastAddr) begin
          cur_epoch_nxt = EpochFirst;
          state_nxt = resume_r ? S_ISSUE : S_IDLE;
          resume_nxt = 1'b0;
        end else begin
          clr_addr_nxt = clr_addr_r + AW'(1);
        end
      end
      S_IDLE: begin
        if (!q_empty) begin
          pop = 1'b1;
          req_nxt = q_head;
          sel_nxt = 2'd0;
          probe_addr_nxt = hash_idx;
          probe_cnt_nxt = '0;
          vnew_nxt = '0;
          state_nxt = S_ISSUE;
          if (q_head.start_pass) begin
            next_mid_nxt = {1'b0, start_wide[IW-1:0]};
            ovf_nxt = 1'b0;
            if (cur_epoch_r == EpochMax) begin
              state_nxt = S_CLEAR;
              resume_nxt = 1'b1;
              clr_addr_nxt = '0;
            end else begin
              cur_epoch_nxt = cur_epoch_r + EpochW'(1);
            end
          end
        end
      end
      S_ISSUE: begin
        mem_re = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (hit) begin
          mid_nxt[sel_r] = rdata_r.mid;
          lookup_done = 1'b1;
        end else if (slot_empty) begin
          if (next_mid_r[IW]) begin
            ovf_nxt = 1'b1;
            mid_nxt[sel_r] = '1;
          end else begin
            mem_we = 1'b1;
            mid_nxt[sel_r] = next_mid_r[IW-1:0];
            vnew_nxt[sel_r] = 1'b1;
            next_mid_nxt = next_mid_r + (IW+1)'(1);
          end
          lookup_done = 1'b1;
        end else if (probe_cnt_r == LastAddr) begin
          ovf_nxt = 1'b1;
          mid_nxt[sel_r] = '1;
          lookup_done = 1'b1;
        end else begin
          probe_addr_nxt = (probe_addr_r == LastAddr) ? '0 : probe_addr_r + AW'(1);
          probe_cnt_nxt = probe_cnt_r + AW'(1);
          state_nxt = S_ISSUE;
        end
        if (lookup_done) begin
          if (sel_r == 2'd2) begin
            emit_nxt = EmitVtxAb;
            state_nxt = S_EMIT;
          end else begin
            sel_nxt = sel_step;
            probe_addr_nxt = hash_idx;
            probe_cnt_nxt = '0;
            state_nxt = S_ISSUE;
          end
        end
      end
      S_EMIT: begin
        if ((emit_r <= EmitVtxCa && !vnew_r[emit_r[1:0]]) || out_slot_free) begin
          if (emit_r == EmitTriMid) begin
            state_nxt = S_IDLE;
          end else begin
            emit_nxt = emit_r + 3'd1;
          end
        end
        if (out_slot_free && !(emit_r <= EmitVtxCa && !vnew_r[emit_r[1:0]])) begin
          out_valid_nxt = 1'b1;
          out_ovf_nxt = ovf_r;
          out_kind_nxt = KindTriangle;
          out_last_nxt = 1'b0;
          case (emit_r) inside
            EmitVtxAb, EmitVtxBc, EmitVtxCa: begin
              out_kind_nxt = KindVertex;
              out_first_nxt = emit_key[KeyW-1:CornerW];
              out_second_nxt = emit_key[CornerW-1:0];
              out_third_nxt = to_field(mid_r[emit_r[1:0]]);
            end
            EmitTriA: begin
              out_first_nxt = req_r.corner_a;
              out_second_nxt = to_field(mid_r[0]);
              out_third_nxt = to_field(mid_r[2]);
            end
            EmitTriB: begin
              out_first_nxt = to_field(mid_r[0]);
              out_second_nxt = req_r.corner_b;
              out_third_nxt = to_field(mid_r[1]);
            end
            EmitTriC: begin
              out_first_nxt = to_field(mid_r[1]);
              out_second_nxt = req_r.corner_c;
              out_third_nxt = to_field(mid_r[2]);
            end
            default: begin
              out_first_nxt = to_field(mid_r[0]);
              out_second_nxt = to_field(mid_r[1]);
              out_third_nxt = to_field(mid_r[2]);
              out_last_nxt = 1'b1;
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[probe_addr_r];
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    sel_r <= sel_nxt;
    probe_addr_r <= probe_addr_nxt;
    probe_cnt_r <= probe_cnt_nxt;
    mid_r <= mid_nxt;
    out_kind_r <= out_kind_nxt;
    out_first_r <= out_first_nxt;
    out_second_r <= out_second_nxt;
    out_third_r <= out_third_nxt;
    out_ovf_r <= out_ovf_nxt;
    out_last_r <= out_last_nxt;
    if (!rst_n) begin
      state_r <= S_CLEAR;
      resume_r <= 1'b0;
      cur_epoch_r <= EpochFirst;
      next_mid_r <= '0;
      ovf_r <= 1'b0;
      clr_addr_r <= '0;
      vnew_r <= '0;
      emit_r <= EmitVtxAb;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      resume_r <= resume_nxt;
      cur_epoch_r <= cur_epoch_nxt;
      next_mid_r <= next_mid_nxt;
      ovf_r <= ovf_nxt;
      clr_addr_r <= clr_addr_nxt;
      vnew_r <= vnew_nxt;
      emit_r <= emit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.kind = out_kind_r;
  assign out_ch.first_index = out_first_r;
  assign out_ch.second_index = out_second_r;
  assign out_ch.third_index = out_third_r;
  assign out_ch.overflow = out_ovf_r;
  assign out_ch.last = out_last_r;

`ifndef SYNTH
  a_epoch_live: assert property (@(posedge clk) disable iff (!rst_n)
    cur_epoch_r != EpochNone)
    else $error("current epoch collides with the cleared mark");

  a_alloc_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK && mem_we) |=> next_mid_r == $past(next_mid_r) + (IW+1)'(1))
    else $error("midpoint counter did not advance by one on insert");

  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && emit_r == EmitTriMid && out_slot_free)
      |=> (out_valid_r && out_last_r && state_r == S_IDLE))
    else $error("final triangle not marked last");
`endif

endmodule

[rtl/triangle_subdivision_indexer_core.sv]
// Midpoint subdivision indexer: each request carries one triangle (three vertex indices)
// and yields up to three new-vertex records (edge order a-b, b-c, c-a, only for edges not
// yet seen in the pass) followed by four triangles, the fourth marked last. Edges live in
// a hashed, linearly probed table of EDGE_MAP_DEPTH slots in one single-port memory with a
// registered read, so each probe issues a read and then checks the registered entry; a
// request is dequeued, probed for each edge (one probe per edge without collisions), and
// then steps through its seven result slots, a slot with a record waiting while the result
// side is not ready. A miss on a full table probes every slot. A start_pass request empties
// the table by advancing an epoch mark; every 255th start_pass, and once after reset, a
// clearing pass sweeps every slot of the table before requests are processed. A two-entry
// queue keeps taking requests while the table works. The user must write start_index
// through cfg_wr_en and cfg_wr_data only while the block is idle; the block does not enforce it.
module triangle_subdivision_indexer_core import tsi_pkg::*; #(
  parameter int EDGE_MAP_DEPTH = 1024,
  parameter int INDEX_WIDTH = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_wr_en,
  input  logic [CornerW-1:0] cfg_wr_data,
  tsi_in_if.sink in_ch,
  tsi_out_if.source out_ch
);

  logic [CornerW-1:0] start_index_r;
  logic push;
  tsi_req_t push_req;
  logic pop;
  tsi_req_t q_head;
  logic q_full;
  logic q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_index_r <= '0;
    end else if (cfg_wr_en) begin
      start_index_r <= cfg_wr_data;
    end
  end

  tsi_front #(
    .INDEX_WIDTH(INDEX_WIDTH)
  ) u_front (
    .in_ch(in_ch),
    .q_full(q_full),
    .push(push),
    .push_req(push_req)
  );

  tsi_queue u_queue (
    .clk(clk),
    .rst_n(rst_n),
    .push(push),
    .push_req(push_req),
    .pop(pop),
    .head(q_head),
    .full(q_full),
    .empty(q_empty)
  );

  tsi_back #(
    .EDGE_MAP_DEPTH(EDGE_MAP_DEPTH),
    .INDEX_WIDTH(INDEX_WIDTH)
  ) u_back (
    .clk(clk),
    .rst_n(rst_n),
    .start_index(start_index_r),
    .q_head(q_head),
    .q_empty(q_empty),
    .pop(pop),
    .out_ch(out_ch)
  );

endmodule

[dv/triangle_subdivision_indexer_core_test.sv]
`timescale 1ns / 1ps

module triangle_subdivision_indexer_core_test import tsi_pkg::*; ();

  localparam int MapDepth = 1024;
  localparam int IndexW = 16;
  localparam int ClkPeriod = 4;
  localparam int ResetCycles = 11;
  localparam int WatchdogLimit = 50000;
  localparam int DrainSlack = 40;
  localparam int RandomItems = 257;
  localparam int HoldOffCycles = 600;
  localparam int ShownMismatches = 10;
  localparam logic KindVertex = 1'b0;
  localparam logic KindTriangle = 1'b1;
  localparam logic [15:0] IndexAllOnes = 16'hFFFF;

  typedef struct packed {
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] c;
    logic start_pass;
  } triangle_t;

  typedef struct packed {
    logic kind;
    logic [15:0] first_idx;
    logic [15:0] second_idx;
    logic [15:0] third_idx;
    logic overflow;
    logic is_last;
  } record_t;

  class subdivision_scoreboard;
    bit [15:0] mid_of_edge[bit [31:0]];
    bit [16:0] next_mid;
    bit overflow_seen;
    bit [15:0] start_index;
    record_t pending_records[$];
    record_t split_records[$];
    int mismatches;
    int records_checked;
    int triangles_noted;
    int midpoints_made;
    int overflow_records;
    int passes;

    function void set_start_index(bit [15:0] value);
      start_index = value;
    endfunction

    function int outstanding();
      return pending_records.size();
    endfunction

    function bit [15:0] resolve_edge(bit [15:0] p, bit [15:0] q);
      bit [15:0] lo;
      bit [15:0] hi;
      bit [15:0] mid;
      bit [31:0] key;
      record_t rec;
      lo = (p < q) ? p : q;
      hi = (p < q) ? q : p;
      key = {lo, hi};
      if (mid_of_edge.exists(key)) return mid_of_edge[key];
      if (mid_of_edge.size() >= MapDepth || next_mid > 17'(IndexAllOnes)) begin
        overflow_seen = 1'b1;
        return IndexAllOnes;
      end
      mid = next_mid[15:0];
      mid_of_edge[key] = mid;
      next_mid = next_mid + 17'd1;
      midpoints_made++;
      rec.kind = KindVertex;
      rec.first_idx = lo;
      rec.second_idx = hi;
      rec.third_idx = mid;
      rec.overflow = 1'b0;
      rec.is_last = 1'b0;
      split_records.insert(split_records.size(), rec);
      return mid;
    endfunction

    function record_t triangle_record(bit [15:0] c0, bit [15:0] c1, bit [15:0] c2,
                                      bit closes);
      record_t rec;
      rec.kind = KindTriangle;
      rec.first_idx = c0;
      rec.second_idx = c1;
      rec.third_idx = c2;
      rec.overflow = 1'b0;
      rec.is_last = closes;
      return rec;
    endfunction

    function void note_triangle(triangle_t t);
      bit [15:0] mab;
      bit [15:0] mbc;
      bit [15:0] mca;
      triangles_noted++;
      if (t.start_pass) begin
        mid_of_edge.delete();
        next_mid = {1'b0, start_index};
        overflow_seen = 1'b0;
        passes++;
      end
      split_records.delete();
      mab = resolve_edge(t.a, t.b);
      mbc = resolve_edge(t.b, t.c);
      mca = resolve_edge(t.c, t.a);
      split_records.insert(split_records.size(), triangle_record(t.a, mab, mca, 1'b0));
      split_records.insert(split_records.size(), triangle_record(mab, t.b, mbc, 1'b0));
      split_records.insert(split_records.size(), triangle_record(mbc, t.c, mca, 1'b0));
      split_records.insert(split_records.size(), triangle_record(mab, mbc, mca, 1'b1));
      foreach (split_records[i]) begin
        split_records[i].overflow = overflow_seen;
        if (overflow_seen) overflow_records++;
        pending_records.insert(pending_records.size(), split_records[i]);
      end
    endfunction

    function void report_mismatch(string what, record_t want, record_t got);
      mismatches++;
      if (mismatches <= ShownMismatches) begin
        $display("[%0t] %s: expected kind=%0b idx=%0d/%0d/%0d ovf=%0b last=%0b",
                 $realtime, what, want.kind, want.first_idx, want.second_idx,
                 want.third_idx, want.overflow, want.is_last);
        $display("    got kind=%0b idx=%0d/%0d/%0d ovf=%0b last=%0b",
                 got.kind, got.first_idx, got.second_idx, got.third_idx,
                 got.overflow, got.is_last);
      end
    endfunction

    function void check_record(record_t got);
      record_t want;
      records_checked++;
      if (pending_records.size() == 0) begin
        report_mismatch("unexpected record", '0, got);
        return;
      end
      want = pending_records.pop_front();
      if (got.kind !== want.kind || got.first_idx !== want.first_idx ||
          got.second_idx !== want.second_idx || got.third_idx !== want.third_idx ||
          got.overflow !== want.overflow || got.is_last !== want.is_last)
        report_mismatch("record mismatch", want, got);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_wr_en;
  logic [CornerW-1:0] cfg_wr_data;
  int burst_left;
  bit pacing;
  int hold_request;

  subdivision_scoreboard sb = new();

  tsi_in_if in_bus();
  tsi_out_if out_bus();

  triangle_subdivision_indexer_core #(
    .EDGE_MAP_DEPTH(MapDepth),
    .INDEX_WIDTH(IndexW)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_ch(in_bus),
    .out_ch(out_bus)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  function automatic triangle_t corners(logic [15:0] a, logic [15:0] b, logic [15:0] c,
                                        logic start_pass);
    triangle_t t;
    t.a = a;
    t.b = b;
    t.c = c;
    t.start_pass = start_pass;
    return t;
  endfunction

  task automatic send_triangle(input triangle_t t);
    in_bus.valid <= 1'b1;
    in_bus.corner_a <= t.a;
    in_bus.corner_b <= t.b;
    in_bus.corner_c <= t.c;
    in_bus.start_pass <= t.start_pass;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    sb.note_triangle(t);
    if (pacing) begin
      burst_left--;
      if (burst_left <= 0) begin
        in_bus.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        burst_left = $urandom_range(1, 24);
      end
    end
  endtask

  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DrainSlack) @(posedge clk);
  endtask

  task automatic write_start_index(input logic [15:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_start_index(value);
  endtask

  initial begin : result_sink
    record_t got;
    int mode;
    int mode_left;
    int hold_left;
    logic [15:0] rx_pattern;
    out_bus.ready <= 1'b0;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    rx_pattern = 16'b1101_0110_0111_0010;
    forever begin
      @(posedge clk);
      if (out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
        got.kind = out_bus.kind;
        got.first_idx = out_bus.first_index;
        got.second_idx = out_bus.second_index;
        got.third_idx = out_bus.third_index;
        got.overflow = out_bus.overflow;
        got.is_last = out_bus.last;
        sb.check_record(got);
      end
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(64, 300);
      end
      mode_left--;
      rx_pattern = {rx_pattern[14:0], rx_pattern[15]};
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        case (mode)
          0: begin
            out_bus.ready <= 1'b1;
          end
          1: begin
            out_bus.ready <= ($urandom_range(0, 3) != 0);
          end
          2: begin
            out_bus.ready <= rx_pattern[0];
          end
          default: begin
            out_bus.ready <= ($urandom_range(0, 3) == 0);
          end
        endcase
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk);
      if ((in_bus.valid === 1'b1 && in_bus.ready === 1'b1) ||
          (out_bus.valid === 1'b1 && out_bus.ready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    triangle_t t;
    triangle_t prev;
    logic [15:0] base;
    logic [15:0] cfg_value;
    int pool;
    int seg;
    int seg_len;
    int sent;
    int pick;

    rst_n <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    in_bus.valid <= 1'b0;
    in_bus.corner_a <= '0;
    in_bus.corner_b <= '0;
    in_bus.corner_c <= '0;
    in_bus.start_pass <= 1'b0;
    hold_request = 0;
    pacing = 1'b1;
    burst_left = 4;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;

    // no pass started yet: allocation runs from zero
    send_triangle(corners(16'd0, 16'd1, 16'd2, 1'b0));
    send_triangle(corners(16'd2, 16'd1, 16'd3, 1'b0));
    send_triangle(corners(16'd5, 16'd5, 16'd5, 1'b0));
    send_triangle(corners(16'hFFFF, 16'd0, 16'hFFFF, 1'b0));

    // index space runs out within one triangle
    wait_drained();
    write_start_index(16'hFFFE);
    send_triangle(corners(16'd10, 16'd20, 16'd30, 1'b1));
    send_triangle(corners(16'd10, 16'd20, 16'd40, 1'b0));
    send_triangle(corners(16'd30, 16'd20, 16'd10, 1'b0));
    send_triangle(corners(16'd1, 16'd2, 16'd3, 1'b1));

    wait_drained();
    write_start_index(16'hFFFF);
    send_triangle(corners(16'd0, 16'd0, 16'd0, 1'b1));
    send_triangle(corners(16'hFFFF, 16'hFFFF, 16'd1, 1'b0));

    wait_drained();
    write_start_index(16'h0000);
    send_triangle(corners(16'hFFFF, 16'hFFFE, 16'hFFFD, 1'b1));
    send_triangle(corners(16'hAAAA, 16'h5555, 16'hFFFF, 1'b0));
    send_triangle(corners(16'h5555, 16'hAAAA, 16'h0000, 1'b0));

    sent = 0;
    seg = 0;
    prev = corners(16'd0, 16'd1, 16'd2, 1'b0);
    while (sent < RandomItems) begin
      wait_drained();
      if (seg == 0 || $urandom_range(0, 1) == 1) begin
        pick = $urandom_range(0, 7);
        case (pick)
          0: cfg_value = 16'h0000;
          1: cfg_value = 16'hFFFF;
          2, 3: cfg_value = 16'($urandom_range(65500, 65535));
          default: cfg_value = 16'($urandom_range(0, 65535));
        endcase
        write_start_index(cfg_value);
      end
      seg_len = $urandom_range(8, 40);
      base = 16'($urandom);
      pool = $urandom_range(3, 24);
      pacing = (seg % 4 != 3);
      if (seg == 2) begin
        pacing = 1'b0;
        hold_request = HoldOffCycles;
      end
      for (int i = 0; i < seg_len && sent < RandomItems; i++) begin
        pick = $urandom_range(0, 99);
        t.a = base + 16'($urandom_range(0, pool - 1));
        t.b = base + 16'($urandom_range(0, pool - 1));
        t.c = base + 16'($urandom_range(0, pool - 1));
        t.start_pass = (i == 0) ? (seg == 0 || $urandom_range(0, 4) != 0) : 1'b0;
        if (pick >= 75 && pick < 87) begin
          t.a = 16'($urandom);
          t.b = 16'($urandom);
          t.c = 16'($urandom);
        end else if (pick >= 87 && pick < 92) begin
          t.start_pass = 1'b1;
        end else if (pick >= 92) begin
          t = corners(prev.b, prev.c, prev.a, t.start_pass);
        end
        send_triangle(t);
        prev = t;
        sent++;
      end
      seg++;
    end
    pacing = 1'b1;

    wait_drained();
    $display("Ran %0d triangles in %0d passes: index exhaustion, repeated edges, long stalls.",
             sb.triangles_noted, sb.passes);
    $display("Checked %0d records: %0d new midpoints, %0d flagged overflow, %0d mismatches.",
             sb.records_checked, sb.midpoints_made, sb.overflow_records, sb.mismatches);
    if (sb.mismatches == 0 && sb.outstanding() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
